// ===== rtl/lobm_pkg.sv =====
// Package for the limit order book matcher.
// Holds widths, reset constants and the sequencer state type; no dependencies.
package lobm_pkg;

    localparam int PriceW = 24;
    localparam int QtyW = 16;
    localparam int SizeW = 32;
    localparam int DefaultLevels = 64;
    localparam logic [PriceW-1:0] InitialPriceReset = 24'd10000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH_RD,
        ST_MATCH,
        ST_SHIFT,
        ST_REST_RD,
        ST_REST,
        ST_INSERT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             side;
        logic [PriceW-1:0] price;
        logic [SizeW-1:0]  size;
    } book_wr_t;

endpackage

// ===== rtl/lobm_book.sv =====
// Price-level storage for both sides of the book.
// Depends on lobm_pkg; one write and one registered read per cycle.
module lobm_book #(
    parameter int LEVELS = lobm_pkg::DefaultLevels,
    parameter int AW = $clog2(LEVELS)
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [AW-1:0]                wr_addr,
    input  lobm_pkg::book_wr_t           wr_data,
    input  logic                         rd_side,
    input  logic [AW-1:0]                rd_addr,
    output logic [lobm_pkg::PriceW-1:0]  rd_price,
    output logic [lobm_pkg::SizeW-1:0]   rd_size
);

    logic [lobm_pkg::PriceW-1:0] price_mem [2**(AW+1)];
    logic [lobm_pkg::SizeW-1:0]  size_mem  [2**(AW+1)];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            price_mem[{wr_data.side, wr_addr}] <= wr_data.price;
            size_mem[{wr_data.side, wr_addr}]  <= wr_data.size;
        end
        rd_price <= price_mem[{rd_side, rd_addr}];
        rd_size  <= size_mem[{rd_side, rd_addr}];
    end

endmodule

// ===== rtl/limit_order_book_matcher.sv =====
// Top level of the limit order book matcher: sequencer, counts and result register.
// Depends on lobm_pkg and lobm_book.
//
// Channel   Direction  Handshake                 Payload
// cfg       in         cfg_valid / cfg_ready     cfg_data
// order     in         in_valid / in_ready       func, limit_price, order_qty
// result    out        out_valid / out_ready     filled_qty .. last_price
//
// An order reads and compares each level it matches, compares levels in turn
// while resting, and moves entries one at a time when levels are removed or one
// is inserted; the single read port of the level memory sets this pace. Reset
// clears counts and sets the last price to 10000.
// The block is not ready while an order is in progress. A stalled result holds
// the sequencer in its final state.
module limit_order_book_matcher #(
    parameter int LEVELS = lobm_pkg::DefaultLevels
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lobm_pkg::PriceW-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          func,
    input  logic [lobm_pkg::PriceW-1:0]   limit_price,
    input  logic [lobm_pkg::QtyW-1:0]     order_qty,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lobm_pkg::QtyW-1:0]     filled_qty,
    output logic [lobm_pkg::QtyW-1:0]     rested_qty,
    output logic [lobm_pkg::QtyW-1:0]     dropped_qty,
    output logic                          book_full,
    output logic                          traded,
    output logic [lobm_pkg::PriceW-1:0]   last_price
);

    localparam int AW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CW = $clog2(LEVELS + 1);
    localparam logic [CW-1:0] LevelsC = CW'(LEVELS);

    lobm_pkg::state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg [2];
    logic [CW-1:0] cnt_next [2];
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] used_reg, used_next;
    logic          side_reg, side_next;
    logic [lobm_pkg::PriceW-1:0] lim_reg, lim_next;
    logic [lobm_pkg::QtyW-1:0]   qty_reg, qty_next, rem_reg, rem_next;
    logic [lobm_pkg::QtyW-1:0]   rest_reg, rest_next, drop_reg, drop_next;
    logic          full_reg, full_next, trd_reg, trd_next;
    logic [lobm_pkg::PriceW-1:0] tp_reg, tp_next;
    logic          outv_reg, outv_next;

    logic                        wr_en, rd_side;
    logic [AW-1:0]               wr_addr, rd_addr;
    lobm_pkg::book_wr_t          wr_data;
    logic [lobm_pkg::PriceW-1:0] rd_price;
    logic [lobm_pkg::SizeW-1:0]  rd_size;
    logic [CW-1:0]               rd_idx;
    logic                        opp, crosses, ahead;
    logic [lobm_pkg::SizeW:0]    sum;

    lobm_book #(.LEVELS(LEVELS), .AW(AW)) u_book (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_side(rd_side), .rd_addr(rd_addr), .rd_price(rd_price), .rd_size(rd_size)
    );

    assign opp = ~side_reg;
    assign cfg_ready = (state_reg == lobm_pkg::ST_IDLE) && !outv_reg;
    assign in_ready = (state_reg == lobm_pkg::ST_IDLE) && !outv_reg && !cfg_valid;
    assign out_valid = outv_reg;
    assign filled_qty = qty_reg - rem_reg;
    assign rested_qty = rest_reg;
    assign dropped_qty = drop_reg;
    assign book_full = full_reg;
    assign traded = trd_reg;
    assign last_price = tp_reg;
    assign crosses = side_reg ? (rd_price >= lim_reg) : (rd_price <= lim_reg);
    assign ahead = side_reg ? (rd_price < lim_reg) : (rd_price > lim_reg);
    assign sum = {1'b0, rd_size} + {{(lobm_pkg::SizeW + 1 - lobm_pkg::QtyW){1'b0}}, rem_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lobm_pkg::ST_IDLE;
            cnt_reg[0] <= '0;
            cnt_reg[1] <= '0;
            tp_reg <= lobm_pkg::InitialPriceReset;
            outv_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg[0] <= cnt_next[0];
            cnt_reg[1] <= cnt_next[1];
            tp_reg <= tp_next;
            outv_reg <= outv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        used_reg <= used_next;
        side_reg <= side_next;
        lim_reg <= lim_next;
        qty_reg <= qty_next;
        rem_reg <= rem_next;
        rest_reg <= rest_next;
        drop_reg <= drop_next;
        full_reg <= full_next;
        trd_reg <= trd_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next[0] = cnt_reg[0];
        cnt_next[1] = cnt_reg[1];
        idx_next = idx_reg;
        used_next = used_reg;
        side_next = side_reg;
        lim_next = lim_reg;
        qty_next = qty_reg;
        rem_next = rem_reg;
        rest_next = rest_reg;
        drop_next = drop_reg;
        full_next = full_reg;
        trd_next = trd_reg;
        tp_next = tp_reg;
        outv_next = outv_reg;
        wr_en = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        rd_side = opp;
        rd_idx = idx_reg;
        case (state_reg)
            lobm_pkg::ST_IDLE:
            begin
                if (cfg_valid && cfg_ready)
                begin
                    tp_next = cfg_data;
                end
                else if (in_valid && in_ready)
                begin
                    side_next = func;
                    lim_next = limit_price;
                    qty_next = order_qty;
                    rem_next = order_qty;
                    rest_next = '0;
                    drop_next = '0;
                    full_next = 1'b0;
                    trd_next = 1'b0;
                    idx_next = '0;
                    used_next = '0;
                    state_next = (order_qty == '0) ? lobm_pkg::ST_DONE
                                                   : lobm_pkg::ST_MATCH_RD;
                end
            end
            lobm_pkg::ST_MATCH_RD:
            begin
                rd_idx = used_reg;
                if (used_reg < cnt_reg[opp] && rem_reg != '0)
                begin
                    state_next = lobm_pkg::ST_MATCH;
                end
                else if (used_reg != '0)
                begin
                    idx_next = '0;
                    rd_idx = used_reg;
                    state_next = lobm_pkg::ST_SHIFT;
                end
                else
                begin
                    idx_next = '0;
                    state_next = (rem_reg != '0) ? lobm_pkg::ST_REST_RD
                                                 : lobm_pkg::ST_DONE;
                end
            end
            lobm_pkg::ST_MATCH:
            begin
                rd_idx = used_reg;
                if (crosses)
                begin
                    trd_next = 1'b1;
                    tp_next = rd_price;
                    if (rd_size > {{(lobm_pkg::SizeW - lobm_pkg::QtyW){1'b0}}, rem_reg})
                    begin
                        wr_en = 1'b1;
                        wr_addr = used_reg[AW-1:0];
                        wr_data.side = opp;
                        wr_data.price = rd_price;
                        wr_data.size = rd_size - {{(lobm_pkg::SizeW - lobm_pkg::QtyW){1'b0}},
                                                  rem_reg};
                        rem_next = '0;
                    end
                    else
                    begin
                        rem_next = rem_reg - rd_size[lobm_pkg::QtyW-1:0];
                        used_next = used_reg + 1'b1;
                        rd_idx = used_reg + 1'b1;
                    end
                    state_next = lobm_pkg::ST_MATCH_RD;
                end
                else
                begin
                    idx_next = '0;
                    rd_idx = used_reg;
                    state_next = (used_reg != '0) ? lobm_pkg::ST_SHIFT
                               : ((rem_reg != '0) ? lobm_pkg::ST_REST_RD
                                                  : lobm_pkg::ST_DONE);
                end
            end
            lobm_pkg::ST_SHIFT:
            begin
                // Read data holds entry idx+used; copy it down to idx.
                if (idx_reg + used_reg < cnt_reg[opp])
                begin
                    wr_en = 1'b1;
                    wr_addr = idx_reg[AW-1:0];
                    wr_data.side = opp;
                    wr_data.price = rd_price;
                    wr_data.size = rd_size;
                    idx_next = idx_reg + 1'b1;
                    rd_idx = idx_reg + used_reg + 1'b1;
                end
                else
                begin
                    cnt_next[opp] = cnt_reg[opp] - used_reg;
                    idx_next = '0;
                    state_next = (rem_reg != '0) ? lobm_pkg::ST_REST_RD
                                                 : lobm_pkg::ST_DONE;
                end
            end
            lobm_pkg::ST_REST_RD:
            begin
                rd_side = side_reg;
                if (idx_reg < cnt_reg[side_reg])
                begin
                    state_next = lobm_pkg::ST_REST;
                end
                else if (cnt_reg[side_reg] >= LevelsC)
                begin
                    drop_next = rem_reg;
                    full_next = 1'b1;
                    state_next = lobm_pkg::ST_DONE;
                end
                else
                begin
                    // Append or insert: walk from the top moving entries up.
                    used_next = cnt_reg[side_reg];
                    rd_idx = cnt_reg[side_reg] - 1'b1;
                    state_next = lobm_pkg::ST_INSERT;
                end
            end
            lobm_pkg::ST_REST:
            begin
                rd_side = side_reg;
                if (ahead)
                begin
                    idx_next = idx_reg + 1'b1;
                    rd_idx = idx_reg + 1'b1;
                    state_next = lobm_pkg::ST_REST_RD;
                end
                else if (rd_price == lim_reg)
                begin
                    wr_en = 1'b1;
                    wr_addr = idx_reg[AW-1:0];
                    wr_data.side = side_reg;
                    wr_data.price = rd_price;
                    wr_data.size = sum[lobm_pkg::SizeW] ? '1 : sum[lobm_pkg::SizeW-1:0];
                    rest_next = rem_reg;
                    state_next = lobm_pkg::ST_DONE;
                end
                else if (cnt_reg[side_reg] >= LevelsC)
                begin
                    drop_next = rem_reg;
                    full_next = 1'b1;
                    state_next = lobm_pkg::ST_DONE;
                end
                else
                begin
                    used_next = cnt_reg[side_reg];
                    rd_idx = cnt_reg[side_reg] - 1'b1;
                    state_next = lobm_pkg::ST_INSERT;
                end
            end
            lobm_pkg::ST_INSERT:
            begin
                // used is the slot being filled; read data holds entry used-1.
                rd_side = side_reg;
                wr_en = 1'b1;
                wr_data.side = side_reg;
                wr_addr = used_reg[AW-1:0];
                if (used_reg > idx_reg)
                begin
                    wr_data.price = rd_price;
                    wr_data.size = rd_size;
                    used_next = used_reg - 1'b1;
                    rd_idx = used_reg - 2'd2;
                end
                else
                begin
                    wr_data.price = lim_reg;
                    wr_data.size = {{(lobm_pkg::SizeW - lobm_pkg::QtyW){1'b0}}, rem_reg};
                    cnt_next[side_reg] = cnt_reg[side_reg] + 1'b1;
                    rest_next = rem_reg;
                    state_next = lobm_pkg::ST_DONE;
                end
            end
            lobm_pkg::ST_DONE:
            begin
                if (!outv_reg)
                begin
                    outv_next = 1'b1;
                end
                else if (out_ready)
                begin
                    outv_next = 1'b0;
                    state_next = lobm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lobm_pkg::ST_IDLE;
            end
        endcase
        rd_addr = rd_idx[AW-1:0];
    end

endmodule
